// ----- sv/tfr_pkg.sv -----
// constants and widths shared by the telemetry response framer
package tfr_pkg;

    localparam int unsigned TYPE_W        = 8;
    localparam int unsigned VALUE_W       = 32;
    localparam int unsigned BYTE_W        = 8;

    localparam logic [7:0] TYPE_RECEIVER  = 8'd121;
    localparam logic [7:0] TYPE_ATTITUDE  = 8'd122;

    localparam logic [7:0] SYNC_DOLLAR    = 8'h24;
    localparam logic [7:0] SYNC_M         = 8'h4D;
    localparam logic [7:0] SYNC_DIR       = 8'h3E;

    localparam int unsigned NUM_RX        = 6;
    localparam int unsigned NUM_ANGLE     = 3;
    localparam int unsigned MAX_VALUES    = 6;
    localparam int unsigned BYTES_PER_VAL = 4;
    localparam int unsigned HEAD_LEN      = 5;
    localparam int unsigned MAX_FRAME     = HEAD_LEN + MAX_VALUES * BYTES_PER_VAL + 1;

    localparam int unsigned VAL_IDX_W     = $clog2(MAX_VALUES);
    localparam int unsigned CNT_W         = $clog2(MAX_VALUES + 1);
    localparam int unsigned POS_W         = $clog2(MAX_FRAME + 1);

    localparam logic [9:0]  SCALE         = 10'd1000;
    localparam logic signed [32:0] OFFSET_TWO = 33'sd131072;
    localparam int unsigned FRAC_W        = 16;
    localparam int unsigned PROD_W        = 41;
    localparam int unsigned SCALED_W      = PROD_W - FRAC_W;

    localparam logic [POS_W-1:0] POS_SYNC0 = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SYNC1 = POS_W'(1);
    localparam logic [POS_W-1:0] POS_SYNC2 = POS_W'(2);
    localparam logic [POS_W-1:0] POS_SIZE  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_TYPE  = POS_W'(4);

endpackage

// ----- sv/telemetry_response_framer.sv -----
// telemetry response framer: one request in, one framed response out byte by byte
//
// A request is answered with a frame of 6, 18 or 30 bytes ('$' 'M' '>', size, type,
// payload, checksum), one byte per cycle while the output is not stalled; the
// checksum byte carries frame_last. The block takes one request at a time: a new
// request is accepted the cycle after the previous frame's checksum byte enters the
// output register. Each payload value goes through one shared two-stage unit (offset
// add with clamp, then a multiply by 1000 and a 16-bit right shift) that runs ahead
// of the byte stream and never stalls it.
module telemetry_response_framer (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic [7:0]               message_type,
    input  logic signed [31:0]       angle_roll,
    input  logic signed [31:0]       angle_pitch,
    input  logic signed [31:0]       angle_heading,
    input  logic signed [31:0]       rx_throttle,
    input  logic signed [31:0]       rx_roll,
    input  logic signed [31:0]       rx_pitch,
    input  logic signed [31:0]       rx_yaw,
    input  logic signed [31:0]       rx_aux_one,
    input  logic signed [31:0]       rx_aux_two,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic [7:0]               frame_byte,
    output logic                     frame_last
);

    localparam int unsigned VAL_IDX_W = tfr_pkg::VAL_IDX_W;
    localparam int unsigned CNT_W     = tfr_pkg::CNT_W;
    localparam int unsigned POS_W     = tfr_pkg::POS_W;
    localparam int unsigned SCALED_W  = tfr_pkg::SCALED_W;
    localparam int unsigned PROD_W    = tfr_pkg::PROD_W;

    logic                      busy_reg;
    logic [7:0]                type_reg;
    logic [7:0]                size_reg;
    logic [CNT_W-1:0]          nvals_reg;
    logic [POS_W-1:0]          len_reg;
    logic signed [31:0]        vals_reg [0:tfr_pkg::MAX_VALUES-1];

    logic [CNT_W-1:0]          calc_cnt_reg;
    logic [31:0]               sum_reg;
    logic                      sum_ok_reg;
    logic [SCALED_W-1:0]       prod_reg;
    logic                      prod_ok_reg;

    logic [POS_W-1:0]          pos_reg;
    logic [7:0]                chk_reg;
    logic                      out_valid_reg;
    logic [7:0]                out_byte_reg;
    logic                      out_last_reg;

    logic                      accept;
    logic                      out_free;
    logic                      is_data;
    logic                      is_last;
    logic [POS_W-1:0]          data_pos;
    logic [1:0]                bpos;
    logic                      have_byte;
    logic                      emit;
    logic                      consume;
    logic                      prod_free;
    logic                      move;
    logic                      sum_free;
    logic                      issue;
    logic [7:0]                next_byte;
    logic [31:0]               prod_word;
    logic signed [32:0]        sel_sum;
    logic [PROD_W-1:0]         product;
    logic [7:0]                req_size;
    logic [CNT_W-1:0]          req_nvals;

    assign accept    = req_valid && !req_stall;
    assign req_stall = busy_reg;

    // request decode
    always_comb
    begin
        if (message_type == tfr_pkg::TYPE_RECEIVER)
        begin
            req_nvals = CNT_W'(tfr_pkg::NUM_RX);
        end
        else if (message_type == tfr_pkg::TYPE_ATTITUDE)
        begin
            req_nvals = CNT_W'(tfr_pkg::NUM_ANGLE);
        end
        else
        begin
            req_nvals = '0;
        end
        req_size = 8'({req_nvals, 2'b00});
    end

    // shared scaling unit
    assign sel_sum  = {vals_reg[calc_cnt_reg[VAL_IDX_W-1:0]][31],
                       vals_reg[calc_cnt_reg[VAL_IDX_W-1:0]]} + tfr_pkg::OFFSET_TWO;
    assign product  = PROD_W'(sum_reg) * PROD_W'(tfr_pkg::SCALE);

    assign data_pos  = pos_reg - POS_W'(tfr_pkg::HEAD_LEN);
    assign bpos      = data_pos[1:0];
    assign is_last   = (pos_reg == len_reg - POS_W'(1));
    assign is_data   = (pos_reg >= POS_W'(tfr_pkg::HEAD_LEN)) && !is_last;
    assign have_byte = !is_data || prod_ok_reg;
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign emit      = busy_reg && out_free && have_byte;
    assign consume   = emit && is_data && (bpos == 2'd3);

    assign prod_free = !prod_ok_reg || consume;
    assign move      = sum_ok_reg && prod_free;
    assign sum_free  = !sum_ok_reg || move;
    assign issue     = busy_reg && (calc_cnt_reg < nvals_reg) && sum_free;

    assign prod_word = 32'(prod_reg);

    always_comb
    begin
        if (pos_reg == tfr_pkg::POS_SYNC0)
        begin
            next_byte = tfr_pkg::SYNC_DOLLAR;
        end
        else if (pos_reg == tfr_pkg::POS_SYNC1)
        begin
            next_byte = tfr_pkg::SYNC_M;
        end
        else if (pos_reg == tfr_pkg::POS_SYNC2)
        begin
            next_byte = tfr_pkg::SYNC_DIR;
        end
        else if (pos_reg == tfr_pkg::POS_SIZE)
        begin
            next_byte = size_reg;
        end
        else if (pos_reg == tfr_pkg::POS_TYPE)
        begin
            next_byte = type_reg;
        end
        else if (is_last)
        begin
            next_byte = chk_reg;
        end
        else
        begin
            next_byte = prod_word[{bpos, 3'b000} +: 8];
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg  <= message_type;
            size_reg  <= req_size;
            len_reg   <= POS_W'(tfr_pkg::HEAD_LEN + 1) + POS_W'({req_nvals, 2'b00});
            if (message_type == tfr_pkg::TYPE_ATTITUDE)
            begin
                vals_reg[0] <= angle_roll;
                vals_reg[1] <= angle_pitch;
                vals_reg[2] <= angle_heading;
                vals_reg[3] <= rx_yaw;
                vals_reg[4] <= rx_aux_one;
                vals_reg[5] <= rx_aux_two;
            end
            else
            begin
                vals_reg[0] <= rx_throttle;
                vals_reg[1] <= rx_roll;
                vals_reg[2] <= rx_pitch;
                vals_reg[3] <= rx_yaw;
                vals_reg[4] <= rx_aux_one;
                vals_reg[5] <= rx_aux_two;
            end
        end
        if (issue)
        begin
            sum_reg <= sel_sum[32] ? 32'd0 : sel_sum[31:0];
        end
        if (move)
        begin
            prod_reg <= product[PROD_W-1:tfr_pkg::FRAC_W];
        end
        if (emit)
        begin
            out_byte_reg <= next_byte;
            out_last_reg <= is_last;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            nvals_reg     <= '0;
            calc_cnt_reg  <= '0;
            sum_ok_reg    <= 1'b0;
            prod_ok_reg   <= 1'b0;
            pos_reg       <= '0;
            chk_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg     <= 1'b1;
                nvals_reg    <= req_nvals;
                calc_cnt_reg <= '0;
                pos_reg      <= '0;
                chk_reg      <= req_size ^ message_type;
            end
            else
            begin
                if (issue)
                begin
                    calc_cnt_reg <= calc_cnt_reg + CNT_W'(1);
                end
                if (emit)
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                    if (is_data)
                    begin
                        chk_reg <= chk_reg ^ next_byte;
                    end
                    if (is_last)
                    begin
                        busy_reg <= 1'b0;
                    end
                end
            end

            if (issue)
            begin
                sum_ok_reg <= 1'b1;
            end
            else if (move)
            begin
                sum_ok_reg <= 1'b0;
            end

            if (move)
            begin
                prod_ok_reg <= 1'b1;
            end
            else if (consume)
            begin
                prod_ok_reg <= 1'b0;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign frame_last = out_last_reg;

endmodule

// ----- tb/sv/tfr_checker.sv -----
// checker for the telemetry response framer: predicts each frame and compares output bytes
`timescale 1ns / 100ps

module tfr_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  logic [7:0]         message_type,
    input  logic signed [31:0] angle_roll,
    input  logic signed [31:0] angle_pitch,
    input  logic signed [31:0] angle_heading,
    input  logic signed [31:0] rx_throttle,
    input  logic signed [31:0] rx_roll,
    input  logic signed [31:0] rx_pitch,
    input  logic signed [31:0] rx_yaw,
    input  logic signed [31:0] rx_aux_one,
    input  logic signed [31:0] rx_aux_two,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  logic [7:0]         frame_byte,
    input  logic               frame_last,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_beat_t;

    frame_beat_t expected_beats[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic logic [31:0] scale_to_milli(input logic signed [31:0] v);
        longint sum;
        sum = longint'(v) + 64'sd131072;
        if (sum < 0)
            return '0;
        return 32'((sum * 1000) >>> 16);
    endfunction

    task automatic push_beat(input logic [7:0] data, input logic last);
        frame_beat_t beat;
        beat.data = data;
        beat.last = last;
        expected_beats.push_back(beat);
    endtask

    task automatic predict_frame(input logic [7:0] kind, input logic [8:0][31:0] vals);
        logic [7:0]  size;
        logic [7:0]  chk;
        logic [31:0] scaled;
        int          first;
        int          count;
        first = 0;
        count = 0;
        if (kind == tfr_pkg::TYPE_RECEIVER)
        begin
            first = tfr_pkg::NUM_ANGLE;
            count = tfr_pkg::NUM_RX;
        end
        else if (kind == tfr_pkg::TYPE_ATTITUDE)
        begin
            first = 0;
            count = tfr_pkg::NUM_ANGLE;
        end
        size = 8'(count * tfr_pkg::BYTES_PER_VAL);
        push_beat(tfr_pkg::SYNC_DOLLAR, 1'b0);
        push_beat(tfr_pkg::SYNC_M, 1'b0);
        push_beat(tfr_pkg::SYNC_DIR, 1'b0);
        push_beat(size, 1'b0);
        push_beat(kind, 1'b0);
        chk = size ^ kind;
        for (int i = 0; i < count; i++)
        begin
            scaled = scale_to_milli(vals[first + i]);
            for (int b = 0; b < tfr_pkg::BYTES_PER_VAL; b++)
            begin
                push_beat(scaled[8*b +: 8], 1'b0);
                chk = chk ^ scaled[8*b +: 8];
            end
        end
        push_beat(chk, 1'b1);
    endtask

    always @(posedge clk)
    begin
        frame_beat_t       want;
        logic [8:0][31:0]  vals;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected frame item: frame_byte %0h frame_last %0b",
                           frame_byte, frame_last);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (frame_byte !== want.data)
                    begin
                        $error("frame_byte mismatch: expected %0h actual %0h",
                               want.data, frame_byte);
                        fail_count = fail_count + 1;
                    end
                    if (frame_last !== want.last)
                    begin
                        $error("frame_last mismatch: expected %0b actual %0b",
                               want.last, frame_last);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                vals[0] = angle_roll;
                vals[1] = angle_pitch;
                vals[2] = angle_heading;
                vals[3] = rx_throttle;
                vals[4] = rx_roll;
                vals[5] = rx_pitch;
                vals[6] = rx_yaw;
                vals[7] = rx_aux_one;
                vals[8] = rx_aux_two;
                predict_frame(message_type, vals);
            end
        end
        pending = expected_beats.size();
    end

endmodule

// ----- tb/sv/tb_telemetry_response_framer.sv -----
// testbench top for the telemetry response framer: stimulus, handshake idling and verdict
`timescale 1ns / 100ps

module tb_telemetry_response_framer;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    logic [7:0]         message_type;
    logic signed [31:0] angle_roll;
    logic signed [31:0] angle_pitch;
    logic signed [31:0] angle_heading;
    logic signed [31:0] rx_throttle;
    logic signed [31:0] rx_roll;
    logic signed [31:0] rx_pitch;
    logic signed [31:0] rx_yaw;
    logic signed [31:0] rx_aux_one;
    logic signed [31:0] rx_aux_two;
    logic               rsp_valid;
    logic               rsp_stall;
    logic [7:0]         frame_byte;
    logic               frame_last;
    int                 fail_count;
    int                 pending;

    int sender_idle_pct;
    int receiver_stall_pct;

    telemetry_response_framer u_top (.*);

    tfr_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    initial
    begin
        rst_n              = 1'b0;
        req_valid          = 1'b0;
        rsp_stall          = 1'b0;
        message_type       = '0;
        angle_roll         = '0;
        angle_pitch        = '0;
        angle_heading      = '0;
        rx_throttle        = '0;
        rx_roll            = '0;
        rx_pitch           = '0;
        rx_yaw             = '0;
        rx_aux_one         = '0;
        rx_aux_two         = '0;
        sender_idle_pct    = 24;
        receiver_stall_pct = 80;
    end

    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [31:0] random_value();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFE_0000 + $urandom_range(4) - 2;
            3: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
            4: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] random_kind();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4)
            return tfr_pkg::TYPE_RECEIVER;
        if (pick < 8)
            return tfr_pkg::TYPE_ATTITUDE;
        return 8'($urandom);
    endfunction

    // called at a falling edge, returns at a falling edge after the item is taken
    task automatic send_request(input logic [7:0] kind, input logic [8:0][31:0] vals);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_valid    <= 1'b0;
            message_type <= 8'($urandom);
            @(negedge clk);
        end
        req_valid     <= 1'b1;
        message_type  <= kind;
        angle_roll    <= vals[0];
        angle_pitch   <= vals[1];
        angle_heading <= vals[2];
        rx_throttle   <= vals[3];
        rx_roll       <= vals[4];
        rx_pitch      <= vals[5];
        rx_yaw        <= vals[6];
        rx_aux_one    <= vals[7];
        rx_aux_two    <= vals[8];
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_uniform(input logic [7:0] kind, input logic [31:0] v);
        logic [8:0][31:0] vals;
        for (int i = 0; i < 9; i++)
            vals[i] = v;
        send_request(kind, vals);
    endtask

    task automatic send_random(input logic [7:0] kind);
        logic [8:0][31:0] vals;
        for (int i = 0; i < 9; i++)
            vals[i] = random_value();
        send_request(kind, vals);
    endtask

    initial
    begin
        logic [8:0][31:0] vals;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed items: extremes, clamp boundary near minus two, unknown types
        send_uniform(tfr_pkg::TYPE_ATTITUDE, 32'h7FFF_FFFF);
        send_uniform(tfr_pkg::TYPE_ATTITUDE, 32'h8000_0000);
        send_uniform(tfr_pkg::TYPE_RECEIVER, 32'h7FFF_FFFF);
        send_uniform(tfr_pkg::TYPE_RECEIVER, 32'h8000_0000);
        vals[0] = 32'hFFFE_0000;
        vals[1] = 32'h0000_0000;
        vals[2] = 32'hFFFF_FFFF;
        vals[3] = 32'hFFFE_0000;
        vals[4] = 32'hFFFD_FFFF;
        vals[5] = 32'hFFFE_0001;
        vals[6] = 32'h0000_0000;
        vals[7] = 32'h0001_0000;
        vals[8] = 32'hFFFF_0000;
        send_request(tfr_pkg::TYPE_RECEIVER, vals);
        send_request(tfr_pkg::TYPE_ATTITUDE, vals);
        vals[0] = 32'h5555_5555;
        vals[1] = 32'hAAAA_AAAA;
        vals[2] = 32'h1234_5678;
        vals[3] = 32'hAAAA_AAAA;
        vals[4] = 32'h5555_5555;
        vals[5] = 32'hFFFE_FFFF;
        vals[6] = 32'h0002_0000;
        vals[7] = 32'hDEAD_BEEF;
        vals[8] = 32'h0000_0001;
        send_request(tfr_pkg::TYPE_RECEIVER, vals);
        send_request(tfr_pkg::TYPE_ATTITUDE, vals);
        send_random(8'd0);
        send_random(8'd255);
        send_random(8'd120);
        send_random(8'd123);
        send_random(8'd1);
        send_random(8'd128);

        repeat (100) send_random(random_kind());

        sender_idle_pct    = 80;
        receiver_stall_pct = 24;
        repeat (100) send_random(random_kind());

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (100) send_random(random_kind());

        req_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
